FILE: hdl/kmp_pkg.sv
// Shared types and constants for the KMP string matcher.
// Used by kmp_ctrl, kmp_dpath and kmp_string_matcher_top; depends on nothing.
`default_nettype none

package kmp_pkg;

    // Sizing of the pattern store and the text position counter.
    localparam int PATTERN_MAX = 64;
    localparam int POS_W       = 32;
    localparam int START_W     = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int PTR_W       = $clog2(PATTERN_MAX + 2);

    // Item modes.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEXT   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_TOOLONG = 3'd4;

    // Input beat.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
        logic       text_first;
        logic       text_last;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [2:0]         status;
        logic [START_W-1:0] match_start;
    } t_out;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHASE,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;
        logic need_result;
        logic step_done;
        logic is_text;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/kmp_ctrl.sv
// Controller state machine for the KMP string matcher.
// Depends on kmp_pkg; drives commands into kmp_dpath.
`default_nettype none

module kmp_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  kmp_pkg::t_sts  i_sts,
    output kmp_pkg::t_cmd  o_cmd
);
    import kmp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.need_search) begin
                        n_state = S_CHASE;
                    end else if (i_sts.need_result) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CHASE: begin
                if (i_sts.step_done) begin
                    n_state = i_sts.is_text ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_CHASE: begin
                o_cmd.step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/kmp_dpath.sv
// Datapath of the KMP string matcher: pattern and failure memories,
// match state, failure-link compare step and the output register. Depends on kmp_pkg.
`default_nettype none

module kmp_dpath (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  kmp_pkg::t_in   i_in_data,
    input  kmp_pkg::t_cmd  i_cmd,
    output kmp_pkg::t_sts  o_sts,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output kmp_pkg::t_out  o_out_data
);
    import kmp_pkg::*;

    // Pattern bytes and failure pointers.
    logic [7:0]       pat_mem  [PATTERN_MAX];
    logic [PTR_W-1:0] fail_mem [PATTERN_MAX];

    // Control state.
    logic [LEN_W-1:0] r_len,  n_len;
    logic [PTR_W-1:0] r_bp,   n_bp;
    logic [PTR_W-1:0] r_mp,   n_mp;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic             r_done, n_done;
    logic             r_ovf,  n_ovf;
    logic             r_out_valid, n_out_valid;

    // Working registers.
    logic [1:0]         r_mode, n_mode;
    logic [7:0]         r_sym,  n_sym;
    logic               r_last, n_last;
    logic [PTR_W-1:0]   r_j,    n_j;
    logic [2:0]         r_res_status, n_res_status;
    logic [START_W-1:0] r_res_start,  n_res_start;
    t_out               r_out_data,   n_out_data;
    logic [7:0]         r_pat_q;
    logic [PTR_W-1:0]   r_fail_q;

    // Memory port signals.
    logic             pat_we;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    logic [PTR_W-1:0] fail_wdata;
    logic [PTR_W-1:0] jm1;
    logic [PTR_W-1:0] jm2;
    logic [LEN_W-1:0] len_m1;

    // Text-byte view after an optional restart.
    logic [PTR_W-1:0] eff_mp;
    logic [POS_W-1:0] eff_pos;
    logic             eff_done;
    logic [PTR_W-1:0] len_ptr;
    logic [PTR_W-1:0] start_j;

    // Compare step signals.
    logic             hit;
    logic [PTR_W-1:0] fail_next;
    logic [PTR_W-1:0] j_fin;
    logic [POS_W:0]   pos_inc;
    logic [POS_W:0]   m_ext;
    logic [POS_W:0]   start_full;

    assign len_ptr   = PTR_W'(r_len);
    assign len_m1    = r_len - LEN_W'(1);
    assign eff_mp    = i_in_data.text_first ? PTR_W'(1) : r_mp;
    assign eff_pos   = i_in_data.text_first ? '0 : r_pos;
    assign eff_done  = i_in_data.text_first ? 1'b0 : r_done;
    assign start_j   = (eff_mp < PTR_W'(1) || eff_mp > len_ptr) ? PTR_W'(1) : eff_mp;

    assign hit       = (r_pat_q == r_sym);
    assign fail_next = (r_fail_q == '0) ? PTR_W'(1) : r_fail_q;
    assign j_fin     = hit ? r_j + PTR_W'(1) : r_j;
    assign pos_inc   = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign m_ext     = (POS_W + 1)'(r_len);
    assign start_full = (pos_inc >= m_ext) ? pos_inc - m_ext : '0;

    // Decide what the offered item needs before it is taken.
    always_comb begin
        o_sts             = '0;
        o_sts.step_done   = ~hit & (r_j > PTR_W'(1)) ? 1'b0 : 1'b1;
        o_sts.is_text     = (r_mode == MODE_TEXT);
        o_sts.out_free    = ~r_out_valid | i_out_ready;
        case (i_in_data.mode)
            MODE_APPEND: begin
                o_sts.need_search = (r_len != LEN_W'(PATTERN_MAX)) && (r_len != '0);
            end
            MODE_TEXT: begin
                o_sts.need_result = 1'b1;
                o_sts.need_search = ~r_ovf & ~eff_done & (r_len != '0);
            end
            default: ;
        endcase
    end

    // Next-state logic for the match state and working registers.
    always_comb begin
        n_len        = r_len;
        n_bp         = r_bp;
        n_mp         = r_mp;
        n_pos        = r_pos;
        n_done       = r_done;
        n_ovf        = r_ovf;
        n_mode       = r_mode;
        n_sym        = r_sym;
        n_last       = r_last;
        n_j          = r_j;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid & ~i_out_ready;
        pat_we       = 1'b0;
        fail_we      = 1'b0;
        fail_waddr   = len_m1[IDX_W-1:0];
        fail_wdata   = j_fin;

        // Take a new item.
        if (i_cmd.take) begin
            n_mode = i_in_data.mode;
            n_sym  = i_in_data.symbol;
            n_last = i_in_data.text_last;
            case (i_in_data.mode)
                MODE_CLEAR: begin
                    n_len  = '0;
                    n_bp   = PTR_W'(1);
                    n_ovf  = 1'b0;
                    n_mp   = PTR_W'(1);
                    n_pos  = '0;
                    n_done = 1'b0;
                end
                MODE_APPEND: begin
                    if (r_len == LEN_W'(PATTERN_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        pat_we = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                        if (r_len == '0) begin
                            // The first pattern byte always restarts at one.
                            fail_we    = 1'b1;
                            fail_waddr = '0;
                            fail_wdata = PTR_W'(1);
                            n_bp       = PTR_W'(1);
                        end else begin
                            n_j = r_bp;
                        end
                    end
                end
                MODE_TEXT: begin
                    n_mp        = eff_mp;
                    n_pos       = eff_pos;
                    n_done      = eff_done;
                    n_res_start = '0;
                    if (r_ovf) begin
                        n_res_status = ST_TOOLONG;
                    end else if (eff_done) begin
                        n_res_status = ST_DONE;
                    end else if (r_len == '0) begin
                        // An empty pattern matches at the first position.
                        n_res_status = ST_MATCH;
                        n_done       = 1'b1;
                    end else begin
                        n_j = start_j;
                    end
                end
                default: ;
            endcase
        end

        // One failure-link step per cycle.
        if (i_cmd.step) begin
            if (!hit && (r_j > PTR_W'(1))) begin
                n_j = fail_next;
            end else if (r_mode == MODE_APPEND) begin
                fail_we = 1'b1;
                n_bp    = j_fin;
            end else begin
                n_res_start  = '0;
                n_res_status = ST_NONE;
                n_mp         = j_fin;
                if (j_fin == len_ptr + PTR_W'(1)) begin
                    n_res_status = ST_MATCH;
                    n_res_start  = START_W'(start_full);
                    n_done       = 1'b1;
                    n_mp         = PTR_W'(1);
                end else if (r_last) begin
                    n_res_status = ST_NOMATCH;
                    n_done       = 1'b1;
                end
                if (r_pos != '1) begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end
        end

        // Move the finished result into the output register.
        if (i_cmd.emit) begin
            n_out_data.status      = r_res_status;
            n_out_data.match_start = r_res_start;
            n_out_valid            = 1'b1;
        end
    end

    // Read addresses follow the next pointer so data lines up with r_j.
    assign jm1 = n_j - PTR_W'(1);
    assign jm2 = n_j - PTR_W'(2);

    // Pattern and failure memories.
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[r_len[IDX_W-1:0]] <= i_in_data.symbol;
        end
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        r_pat_q  <= pat_mem[jm1[IDX_W-1:0]];
        r_fail_q <= fail_mem[jm2[IDX_W-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_bp        <= PTR_W'(1);
            r_mp        <= PTR_W'(1);
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_bp        <= n_bp;
            r_mp        <= n_mp;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_j          <= n_j;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_out_data   <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: hdl/kmp_string_matcher_top.sv
// KMP matcher. Clear, an ignored mode, the first pattern byte and an append to a full
// pattern are finished when taken; any other append follows k failure links. A text byte
// follows k links if a search is needed, then waits out output stalls for its result beat;
// k counts links followed, one per memory read, averaging at most about one per byte.
// One item is in flight at a time. Reset (synchronous, active low) empties the pattern,
// restarts the search and drops any result beat; memory contents are left as they were.
`default_nettype none

module kmp_string_matcher_top (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  kmp_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output kmp_pkg::t_out  o_out_data
);
    import kmp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and compare datapath.
    kmp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // A clear finishes in its own cycle, so the input side stays open.
    a_clear_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == MODE_CLEAR) |=> o_in_ready)
        else $error("input not ready after a clear beat");

    // A text beat always leads to a busy sequencer in the next cycle.
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == MODE_TEXT) |=> !o_in_ready)
        else $error("sequencer idle right after a text beat");

    // Only a match beat carries a nonzero start.
    a_start_only_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.match_start != '0) |-> o_out_data.status == ST_MATCH)
        else $error("nonzero match start without a match");
`endif

endmodule

`default_nettype wire
